@@ hdl/hpsc_pkg.sv @@
// Shared constants, types and the exponential demand table for the heater
// power safety controller. No dependencies.
`timescale 1ns / 1ps

package hpsc_pkg;

  localparam int STAGES            = 6;
  localparam int TEMP_FRAC_BITS    = 4;
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES);

  localparam int TEMP_W  = 16;
  localparam int LIMIT_W = 11;
  localparam int POWER_W = 7;
  localparam int Q16_W   = 17;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 9;
  localparam int MPG_W   = POWER_W + Q16_W;
  localparam int P_W     = MPG_W + Q16_W - 16;

  localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'(80 << TEMP_FRAC_BITS);

  // Attenuation windows
  localparam logic signed [ERR_W-1:0] BED_START  = 17'(35 << TEMP_FRAC_BITS);
  localparam logic signed [ERR_W-1:0] BED_SPAN   = 17'(20 << TEMP_FRAC_BITS);
  localparam logic signed [ERR_W-1:0] SURF_START = 17'(30 << TEMP_FRAC_BITS);
  localparam logic signed [ERR_W-1:0] SURF_SPAN  = 17'(15 << TEMP_FRAC_BITS);

  // round(d^2 * 2^16 / span^2) reduced to (32 d^2 + 25) / 50 for the bed and
  // (512 d^2 + 225) / 450 for the surface; divisions by reciprocal multiply.
  localparam int BED_XW   = 23;
  localparam int BED_MW   = 23;
  localparam int BED_PW   = 46;
  localparam int BED_SH   = 28;
  localparam logic [BED_MW-1:0] BED_RECIP = 23'd5368710;
  localparam logic [BED_XW-1:0] BED_BIAS  = 23'd25;

  localparam int SURF_XW  = 25;
  localparam int SURF_MW  = 26;
  localparam int SURF_PW  = 51;
  localparam int SURF_SH  = 34;
  localparam logic [SURF_MW-1:0] SURF_RECIP = 26'd38177488;
  localparam logic [SURF_XW-1:0] SURF_BIAS  = 25'd225;

  // Register indexes
  localparam logic [1:0] REG_MAX_POWER     = 2'd0;
  localparam logic [1:0] REG_BED_LIMIT     = 2'd1;
  localparam logic [1:0] REG_SURFACE_LIMIT = 2'd2;
  localparam logic [1:0] REG_LIQUID_LIMIT  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DISC = 2'd1,
    ST_HOT  = 2'd2
  } status_e;

  typedef struct packed {
    logic              full;
    logic              zero;
    logic [DIFF_W-1:0] d;
  } atten_in_t;

  typedef struct packed {
    status_e st_bed;
    status_e st_surf;
    status_e st_liq;
    logic    fault;
    logic    kill;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [Q16_W-1:0] g;
    atten_in_t        bed;
    atten_in_t        surf;
  } front_t;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    side_t              side;
  } result_t;

  // exp(-0.7 * i / 2^TEMP_FRAC_BITS) in Q1.16, built at elaboration.
  localparam logic [63:0] EXP_DEN    = 64'(10 << TEMP_FRAC_BITS);
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  typedef logic [EXP_TABLE_ENTRIES-1:0][Q16_W-1:0] exp_rom_t;

  function automatic logic [Q16_W-1:0] exp_entry(input logic [63:0] idx);
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] r;
    longint      sum;
    a = 64'd7 * idx;
    n = a / EXP_DEN;
    if (n >= 64'd12) begin
      return '0;
    end
    f = ((a % EXP_DEN) << 32) / EXP_DEN;
    term = 64'd1 << 32;
    sum = longint'(term);
    for (int k = 1; k <= 13; k++) begin
      term = ((term * f) >> 32) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = 64'(sum);
    for (int j = 0; j < 12; j++) begin
      if (64'(j) < n) begin
        e = (e * EXP_M1_Q32) >> 32;
      end
    end
    r = (e + 64'd32768) >> 16;
    return r[Q16_W-1:0];
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      rom[i] = exp_entry(64'(i));
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

@@ hdl/hpsc_front.sv @@
// First pipeline stage: sensor classification, demand lookup from the
// exponential table and attenuation window offsets. Depends on hpsc_pkg.
`timescale 1ns / 1ps

module hpsc_front import hpsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [LIMIT_W-1:0]       target_temp_i,
  input  logic                     run_enable_i,
  input  logic signed [TEMP_W-1:0] bed_temp_i,
  input  logic signed [TEMP_W-1:0] surface_temp_i,
  input  logic signed [TEMP_W-1:0] liquid_temp_i,
  input  logic [LIMIT_W-1:0]       bed_limit_i,
  input  logic [LIMIT_W-1:0]       surface_limit_i,
  input  logic [LIMIT_W-1:0]       liquid_limit_i,
  output front_t                   front_o
);

  front_t                  front_d, front_q;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] d_bed;
  logic signed [ERR_W-1:0] d_surf;

  function automatic status_e classify(input logic signed [TEMP_W-1:0] t,
                                       input logic [LIMIT_W-1:0] lim);
    status_e st;
    if (t < 0 || t > TEMP_MAX) begin
      st = ST_DISC;
    end else if (t[LIMIT_W-1:0] > lim) begin
      st = ST_HOT;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

  always_comb begin
    front_d.side.st_bed  = classify(bed_temp_i, bed_limit_i);
    front_d.side.st_surf = classify(surface_temp_i, surface_limit_i);
    front_d.side.st_liq  = classify(liquid_temp_i, liquid_limit_i);
    front_d.side.fault   = (front_d.side.st_bed != ST_OK) ||
                           (front_d.side.st_surf != ST_OK) ||
                           (front_d.side.st_liq != ST_OK);
    front_d.side.kill    = front_d.side.fault || !run_enable_i;

    err = $signed({{(ERR_W-LIMIT_W){1'b0}}, target_temp_i}) -
          $signed({liquid_temp_i[TEMP_W-1], liquid_temp_i});
    if (err <= 0) begin
      front_d.g = '0;
    end else if (err >= $signed(ERR_W'(EXP_TABLE_ENTRIES))) begin
      front_d.g = ONE_Q16;
    end else begin
      front_d.g = ONE_Q16 - EXP_ROM[err[EXP_IDX_W-1:0]];
    end

    d_bed = $signed({bed_temp_i[TEMP_W-1], bed_temp_i}) - BED_START;
    front_d.bed.full = (d_bed <= 0);
    front_d.bed.zero = (d_bed >= BED_SPAN);
    front_d.bed.d    = d_bed[DIFF_W-1:0];

    d_surf = $signed({surface_temp_i[TEMP_W-1], surface_temp_i}) - SURF_START;
    front_d.surf.full = (d_surf <= 0);
    front_d.surf.zero = (d_surf >= SURF_SPAN);
    front_d.surf.d    = d_surf[DIFF_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

@@ hdl/hpsc_atten.sv @@
// Stages two to four: quadratic attenuation of bed and surface readings,
// square, reciprocal multiply, then subtract from one. Depends on hpsc_pkg.
`timescale 1ns / 1ps

module hpsc_atten import hpsc_pkg::*; (
  input  logic               clk_i,
  input  logic [STAGES-1:0]  stage_en_i,
  input  atten_in_t          bed_i,
  input  atten_in_t          surf_i,
  output logic [Q16_W-1:0]   psi_bed_o,
  output logic [Q16_W-1:0]   psi_surf_o
);

  logic [2*DIFF_W-1:0]   sq_bed_q;
  logic [2*DIFF_W-3:0]   sq_surf_q;
  logic [1:0]            fl_bed2_q, fl_surf2_q;
  logic [BED_XW-1:0]     x_bed;
  logic [SURF_XW-1:0]    x_surf;
  logic [BED_PW-1:0]     prod_bed_q;
  logic [SURF_PW-1:0]    prod_surf_q;
  logic [1:0]            fl_bed3_q, fl_surf3_q;
  logic [Q16_W-1:0]      q_bed, q_surf;
  logic [Q16_W-1:0]      psi_bed_d, psi_surf_d;
  logic [Q16_W-1:0]      psi_bed_q, psi_surf_q;

  // stage 2: squares
  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      sq_bed_q   <= {{DIFF_W{1'b0}}, bed_i.d} * {{DIFF_W{1'b0}}, bed_i.d};
      sq_surf_q  <= {{(DIFF_W-1){1'b0}}, surf_i.d[DIFF_W-2:0]} *
                    {{(DIFF_W-1){1'b0}}, surf_i.d[DIFF_W-2:0]};
      fl_bed2_q  <= {bed_i.full, bed_i.zero};
      fl_surf2_q <= {surf_i.full, surf_i.zero};
    end
  end

  // stage 3: rounded quotient by reciprocal
  assign x_bed  = {sq_bed_q, 5'b0} + BED_BIAS;
  assign x_surf = {sq_surf_q, 9'b0} + SURF_BIAS;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      prod_bed_q  <= BED_PW'(x_bed) * BED_PW'(BED_RECIP);
      prod_surf_q <= SURF_PW'(x_surf) * SURF_PW'(SURF_RECIP);
      fl_bed3_q   <= fl_bed2_q;
      fl_surf3_q  <= fl_surf2_q;
    end
  end

  // stage 4: psi = 1 - quotient, clamped outside the window
  assign q_bed  = prod_bed_q[BED_SH +: Q16_W];
  assign q_surf = prod_surf_q[SURF_SH +: Q16_W];

  always_comb begin
    if (fl_bed3_q[1]) begin
      psi_bed_d = ONE_Q16;
    end else if (fl_bed3_q[0]) begin
      psi_bed_d = '0;
    end else begin
      psi_bed_d = ONE_Q16 - q_bed;
    end
    if (fl_surf3_q[1]) begin
      psi_surf_d = ONE_Q16;
    end else if (fl_surf3_q[0]) begin
      psi_surf_d = '0;
    end else begin
      psi_surf_d = ONE_Q16 - q_surf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      psi_bed_q  <= psi_bed_d;
      psi_surf_q <= psi_surf_d;
    end
  end

  assign psi_bed_o  = psi_bed_q;
  assign psi_surf_o = psi_surf_q;

endmodule

@@ hdl/hpsc_scale.sv @@
// Stages two to six: demand times max power, then the two attenuations,
// plus the status sideband delay line. Depends on hpsc_pkg.
`timescale 1ns / 1ps

module hpsc_scale import hpsc_pkg::*; (
  input  logic               clk_i,
  input  logic [STAGES-1:0]  stage_en_i,
  input  front_t             front_i,
  input  logic [POWER_W-1:0] max_power_i,
  input  logic [Q16_W-1:0]   psi_bed_i,
  input  logic [Q16_W-1:0]   psi_surf_i,
  output result_t            result_o
);

  side_t              side2_q, side3_q, side4_q, side5_q;
  logic [MPG_W-1:0]   mpg2_q, mpg3_q, mpg4_q;
  logic [MPG_W+Q16_W-1:0] prod5;
  logic [P_W-1:0]     p5_q;
  logic [Q16_W-1:0]   psi_surf5_q;
  logic [P_W+Q16_W-1:0] prod6;
  result_t            res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      side2_q <= front_i.side;
      mpg2_q  <= {{Q16_W{1'b0}}, max_power_i} * {{POWER_W{1'b0}}, front_i.g};
    end
    if (stage_en_i[2]) begin
      side3_q <= side2_q;
      mpg3_q  <= mpg2_q;
    end
    if (stage_en_i[3]) begin
      side4_q <= side3_q;
      mpg4_q  <= mpg3_q;
    end
  end

  assign prod5 = (MPG_W+Q16_W)'(mpg4_q) * (MPG_W+Q16_W)'(psi_bed_i);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      side5_q     <= side4_q;
      p5_q        <= prod5[16 +: P_W];
      psi_surf5_q <= psi_surf_i;
    end
  end

  assign prod6 = (P_W+Q16_W)'(p5_q) * (P_W+Q16_W)'(psi_surf5_q);

  always_comb begin
    res_d.side  = side5_q;
    res_d.power = side5_q.kill ? '0 : prod6[32 +: POWER_W];
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[5]) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

@@ hdl/heater_power_safety_controller_top.sv @@
// Heater power safety controller, top level: stream ports, configuration
// registers and pipeline flow control. Depends on hpsc_pkg and submodules.
`timescale 1ns / 1ps

// Six-stage pipeline taking one transaction per clock unless the output
// stalls. A transaction accepted at the input is held in stage one and moves
// through stages two to six in order; stage six drives the output. Each stage
// register holds its data while the next one is full and stalled, and empty
// stages fill in, so back-pressure on the output never drops or repeats a
// transaction. Stage one classifies the sensors and looks up demand, two to
// four build the bed and surface attenuations, five and six apply them to
// max_power times demand. Configuration writes take effect on the next
// transaction and must only be issued while the pipeline is empty.
module heater_power_safety_controller_top import hpsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_temp[10:0], run_enable[11], bed_temp[27:12], surface_temp[43:28],
  // liquid_temp[59:44], zero fill[63:60]
  input  logic [63:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // power_percent[6:0], any_fault[7], bed_status[9:8], surface_status[11:10],
  // liquid_status[13:12], zero fill[15:14]
  output logic [15:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [10:0]  cfg_wdata_i
);

  logic [POWER_W-1:0] max_power_q;
  logic [LIMIT_W-1:0] bed_limit_q, surface_limit_q, liquid_limit_q;
  logic [STAGES-1:0]  vld_d, vld_q;
  logic [STAGES-1:0]  en;
  front_t             front;
  logic [Q16_W-1:0]   psi_bed, psi_surf;
  result_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q     <= 7'd100;
      bed_limit_q     <= 11'd880;
      surface_limit_q <= 11'd720;
      liquid_limit_q  <= 11'd640;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_POWER:     max_power_q     <= cfg_wdata_i[POWER_W-1:0];
        REG_BED_LIMIT:     bed_limit_q     <= cfg_wdata_i;
        REG_SURFACE_LIMIT: surface_limit_q <= cfg_wdata_i;
        REG_LIQUID_LIMIT:  liquid_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage loads when empty or when its successor loads
  always_comb begin
    en[STAGES-1] = !vld_q[STAGES-1] || m_axis_tready;
    for (int k = STAGES-2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  hpsc_front u_front (
    .clk_i           (clk_i),
    .en_i            (en[0]),
    .target_temp_i   (s_axis_tdata[10:0]),
    .run_enable_i    (s_axis_tdata[11]),
    .bed_temp_i      (s_axis_tdata[27:12]),
    .surface_temp_i  (s_axis_tdata[43:28]),
    .liquid_temp_i   (s_axis_tdata[59:44]),
    .bed_limit_i     (bed_limit_q),
    .surface_limit_i (surface_limit_q),
    .liquid_limit_i  (liquid_limit_q),
    .front_o         (front)
  );

  hpsc_atten u_atten (
    .clk_i      (clk_i),
    .stage_en_i (en),
    .bed_i      (front.bed),
    .surf_i     (front.surf),
    .psi_bed_o  (psi_bed),
    .psi_surf_o (psi_surf)
  );

  hpsc_scale u_scale (
    .clk_i       (clk_i),
    .stage_en_i  (en),
    .front_i     (front),
    .max_power_i (max_power_q),
    .psi_bed_i   (psi_bed),
    .psi_surf_i  (psi_surf),
    .result_o    (result)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[STAGES-1];
  assign m_axis_tdata  = {2'b00, result.side.st_liq, result.side.st_surf,
                          result.side.st_bed, result.side.fault, result.power};

endmodule

@@ test/heater_power_safety_controller_tb.sv @@
// Self-checking testbench for heater_power_safety_controller_top: directed plan
// then constrained-by-hand random stimulus against a local drive predictor.
// Depends on hpsc_pkg and the controller RTL.
`timescale 1ns / 1ps

module testbench;
  import hpsc_pkg::*;

  localparam int LIMIT_CYCLES  = 300000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 75;
  localparam int BED_FADE_LO   = 35 << TEMP_FRAC_BITS;
  localparam int BED_FADE_SPAN = 20 << TEMP_FRAC_BITS;
  localparam int SRF_FADE_LO   = 30 << TEMP_FRAC_BITS;
  localparam int SRF_FADE_SPAN = 15 << TEMP_FRAC_BITS;
  localparam int READ_MAX      = 80 << TEMP_FRAC_BITS;
  localparam logic [63:0] DECAY_E1_Q32 = 64'd1580030169;

  typedef struct packed {
    logic signed [15:0] liq;
    logic signed [15:0] srf;
    logic signed [15:0] bed;
    logic               run;
    logic [10:0]        target;
  } sample_t;

  typedef struct {
    logic [6:0] power;
    logic       fault;
    status_e    st_bed;
    status_e    st_srf;
    status_e    st_liq;
  } drive_t;

  typedef struct {
    bit         is_cfg;
    logic [1:0] idx;
    logic [10:0] val;
    sample_t    s;
    bit         known;
    drive_t     want;
  } plan_step_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [10:0] cfg_wdata_i   = '0;

  logic [6:0]  cur_max_power = 7'd100;
  logic [10:0] cur_bed_lim   = 11'd880;
  logic [10:0] cur_srf_lim   = 11'd720;
  logic [10:0] cur_liq_lim   = 11'd640;

  int unsigned decay_q16 [EXP_TABLE_ENTRIES];
  drive_t      pending_drive [$];
  plan_step_t  plan [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  bit          calm        = 1'b0;
  drive_t      got_drive;
  drive_t      want_drive;

  heater_power_safety_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // exp(-0.7 * i / 2^frac) in Q1.16: e^-1 powers times a Taylor series
  function automatic int unsigned decay_entry(int unsigned i);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] term;
    logic [63:0] e;
    longint      acc;
    num = 64'd7 * 64'(i);
    den = 64'(10 << TEMP_FRAC_BITS);
    whole = num / den;
    if (whole >= 64'd12) begin
      return 0;
    end
    frac = ((num % den) << 32) / den;
    term = 64'd1 << 32;
    acc = longint'(term);
    for (int k = 1; k <= 13; k++) begin
      term = ((term * frac) >> 32) / 64'(k);
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    e = 64'(acc);
    while (whole > 0) begin
      e = (e * DECAY_E1_Q32) >> 32;
      whole = whole - 1;
    end
    return int'((e + 64'd32768) >> 16);
  endfunction

  function automatic logic [63:0] fade_q16(int t, int lo, int span);
    int          d;
    logic [63:0] dd;
    logic [63:0] s2;
    d = t - lo;
    if (d <= 0) begin
      return 64'd65536;
    end
    if (d >= span) begin
      return 64'd0;
    end
    dd = 64'(d) * 64'(d);
    s2 = 64'(span) * 64'(span);
    return 64'd65536 - ((dd * 64'd65536 + s2 / 2) / s2);
  endfunction

  function automatic status_e sensor_state(logic signed [15:0] t, logic [10:0] lim);
    int v;
    v = int'(t);
    if (v < 0 || v > READ_MAX) begin
      return ST_DISC;
    end
    if (v > int'(lim)) begin
      return ST_HOT;
    end
    return ST_OK;
  endfunction

  function automatic drive_t predict_drive(sample_t s);
    drive_t      d;
    int          err;
    logic [63:0] g;
    logic [63:0] p;
    d.st_bed = sensor_state(s.bed, cur_bed_lim);
    d.st_srf = sensor_state(s.srf, cur_srf_lim);
    d.st_liq = sensor_state(s.liq, cur_liq_lim);
    d.fault  = (d.st_bed != ST_OK) || (d.st_srf != ST_OK) || (d.st_liq != ST_OK);
    d.power  = '0;
    if (!d.fault && s.run) begin
      err = int'(s.target) - int'(s.liq);
      g = 64'd0;
      if (err >= EXP_TABLE_ENTRIES) begin
        g = 64'd65536;
      end else if (err > 0) begin
        g = 64'd65536 - 64'(decay_q16[err]);
      end
      p = (64'(cur_max_power) * g * fade_q16(int'(s.bed), BED_FADE_LO, BED_FADE_SPAN)) >> 16;
      p = (p * fade_q16(int'(s.srf), SRF_FADE_LO, SRF_FADE_SPAN)) >> 32;
      d.power = p[6:0];
    end
    return d;
  endfunction

  // ---------------------------------------------------------------- plan

  function automatic drive_t drive_of(int p, bit f, status_e sb, status_e ss, status_e sl);
    drive_t d;
    d.power  = 7'(p);
    d.fault  = f;
    d.st_bed = sb;
    d.st_srf = ss;
    d.st_liq = sl;
    return d;
  endfunction

  function automatic sample_t sample_of(int t, bit r, int b, int sf, int l);
    sample_t s;
    s.target = 11'(t);
    s.run    = r;
    s.bed    = 16'(b);
    s.srf    = 16'(sf);
    s.liq    = 16'(l);
    return s;
  endfunction

  function automatic plan_step_t blank_step();
    plan_step_t st;
    st.is_cfg = 1'b0;
    st.idx    = '0;
    st.val    = '0;
    st.s      = '0;
    st.known  = 1'b0;
    st.want   = drive_of(0, 1'b0, ST_OK, ST_OK, ST_OK);
    return st;
  endfunction

  task automatic plan_cfg(logic [1:0] idx, logic [10:0] val);
    plan_step_t st;
    st = blank_step();
    st.is_cfg = 1'b1;
    st.idx    = idx;
    st.val    = val;
    plan.push_back(st);
  endtask

  task automatic plan_item(int t, bit r, int b, int sf, int l);
    plan_step_t st;
    st = blank_step();
    st.s = sample_of(t, r, b, sf, l);
    plan.push_back(st);
  endtask

  task automatic plan_known(int t, bit r, int b, int sf, int l,
                            int p, bit f, status_e sb, status_e ss, status_e sl);
    plan_step_t st;
    st = blank_step();
    st.s     = sample_of(t, r, b, sf, l);
    st.known = 1'b1;
    st.want  = drive_of(p, f, sb, ss, sl);
    plan.push_back(st);
  endtask

  task automatic build_plan();
    // reset limits: 880 / 720 / 640, max_power 100
    plan_known(1280, 0, 0, 0, 0, 0, 0, ST_OK, ST_OK, ST_OK);
    plan_known(1280, 1, 0, 0, 0, 100, 0, ST_OK, ST_OK, ST_OK);
    plan_known(0, 1, 0, 0, 0, 0, 0, ST_OK, ST_OK, ST_OK);
    plan_known(200, 1, 0, 0, 300, 0, 0, ST_OK, ST_OK, ST_OK);
    plan_item(1, 1, 0, 0, 0);
    plan_item(255, 1, 0, 0, 0);
    plan_known(256, 1, 0, 0, 0, 100, 0, ST_OK, ST_OK, ST_OK);
    plan_known(2047, 1, 0, 0, 0, 100, 0, ST_OK, ST_OK, ST_OK);
    plan_known(1280, 1, -32768, 0, 0, 0, 1, ST_DISC, ST_OK, ST_OK);
    plan_known(1280, 1, 0, 32767, 0, 0, 1, ST_OK, ST_DISC, ST_OK);
    plan_known(1280, 1, 0, 0, -1, 0, 1, ST_OK, ST_OK, ST_DISC);
    plan_known(1280, 1, 0, 0, 1281, 0, 1, ST_OK, ST_OK, ST_DISC);
    plan_known(1280, 1, 881, 721, 641, 0, 1, ST_HOT, ST_HOT, ST_HOT);
    plan_known(1280, 1, 880, 720, 640, 0, 0, ST_OK, ST_OK, ST_OK);
    plan_item(1280, 1, 561, 481, 0);
    plan_item(1280, 1, 879, 719, 0);
    plan_known(1280, 1, 560, 480, 0, 100, 0, ST_OK, ST_OK, ST_OK);
    // upper bits of wdata are dropped, giving max_power 127
    plan_cfg(REG_MAX_POWER, 11'h7FF);
    plan_known(1280, 1, 0, 0, 0, 127, 0, ST_OK, ST_OK, ST_OK);
    plan_item(300, 1, 600, 500, 200);
    plan_cfg(REG_BED_LIMIT, 11'd1280);
    plan_cfg(REG_SURFACE_LIMIT, 11'd0);
    plan_cfg(REG_LIQUID_LIMIT, 11'd0);
    plan_known(1280, 1, 1280, 0, 0, 0, 0, ST_OK, ST_OK, ST_OK);
    plan_known(1280, 1, 1281, 1, 1, 0, 1, ST_DISC, ST_HOT, ST_HOT);
    plan_known(0, 1, 0, 1281, 0, 0, 1, ST_OK, ST_DISC, ST_OK);
    plan_cfg(REG_MAX_POWER, 11'd0);
    plan_known(1280, 1, 0, 0, 0, 0, 0, ST_OK, ST_OK, ST_OK);
  endtask

  // ---------------------------------------------------------------- random

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(19, 0);
    if (r < 12) begin
      return 0;
    end
    if (r < 18) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [15:0] reading(int lo, int hi, int lim);
    int top;
    top = (lim < READ_MAX) ? lim : READ_MAX;
    if (hi > top) begin
      hi = top;
    end
    if (lo > hi) begin
      lo = 0;
    end
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic signed [15:0] noisy_reading(int lim);
    case ($urandom_range(7, 0))
      0, 1: return 16'($urandom);
      2: return -16'sd1;
      3: return 16'(READ_MAX);
      4: return 16'(READ_MAX + 1);
      5: return 16'(lim);
      6: return 16'(lim + 1);
      default: return reading(0, READ_MAX, 2047);
    endcase
  endfunction

  function automatic sample_t make_sample();
    sample_t s;
    int      t;
    if ($urandom_range(9, 0) < 7) begin
      s.run = ($urandom_range(15, 0) != 0);
      s.bed = ($urandom_range(2, 0) == 0) ? reading(0, READ_MAX, int'(cur_bed_lim))
                                          : reading(520, 900, int'(cur_bed_lim));
      s.srf = ($urandom_range(2, 0) == 0) ? reading(0, READ_MAX, int'(cur_srf_lim))
                                          : reading(440, 740, int'(cur_srf_lim));
      s.liq = reading(0, READ_MAX, int'(cur_liq_lim));
      if ($urandom_range(3, 0) != 0) begin
        t = int'(s.liq) + int'($urandom_range(320, 0));
        s.target = (t > 2047) ? 11'd2047 : 11'(t);
      end else begin
        s.target = 11'($urandom_range(2047, 0));
      end
    end else begin
      s.run    = 1'($urandom);
      s.target = 11'($urandom_range(2047, 0));
      s.bed    = noisy_reading(int'(cur_bed_lim));
      s.srf    = noisy_reading(int'(cur_srf_lim));
      s.liq    = noisy_reading(int'(cur_liq_lim));
    end
    return s;
  endfunction

  function automatic logic [10:0] random_limit();
    if ($urandom_range(3, 0) == 0) begin
      return 11'($urandom_range(2047, 0));
    end
    return 11'($urandom_range(READ_MAX, 0));
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAX_POWER:     cur_max_power = val[6:0];
      REG_BED_LIMIT:     cur_bed_lim   = val;
      REG_SURFACE_LIMIT: cur_srf_lim   = val;
      REG_LIQUID_LIMIT:  cur_liq_lim   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_drive.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  task automatic send_sample(sample_t s, bit known, drive_t want);
    int gap;
    s_axis_tdata  <= {4'b0000, s};
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_drive.push_back(known ? want : predict_drive(s));
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(4, 0) == 0) begin
      stall_left    <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_drive.power  = m_axis_tdata[6:0];
      got_drive.fault  = m_axis_tdata[7];
      got_drive.st_bed = status_e'(m_axis_tdata[9:8]);
      got_drive.st_srf = status_e'(m_axis_tdata[11:10]);
      got_drive.st_liq = status_e'(m_axis_tdata[13:12]);
      if (pending_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected transaction, tdata %h", $time, m_axis_tdata);
        end
      end else begin
        want_drive = pending_drive.pop_front();
        if (got_drive.power != want_drive.power || got_drive.fault != want_drive.fault ||
            got_drive.st_bed != want_drive.st_bed || got_drive.st_srf != want_drive.st_srf ||
            got_drive.st_liq != want_drive.st_liq) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch exp power %0d fault %0d st %0d/%0d/%0d", $time,
                     want_drive.power, want_drive.fault, want_drive.st_bed,
                     want_drive.st_srf, want_drive.st_liq);
            $display("%0t:          got power %0d fault %0d st %0d/%0d/%0d", $time,
                     got_drive.power, got_drive.fault, got_drive.st_bed,
                     got_drive.st_srf, got_drive.st_liq);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[heater_power_safety_controller_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    drive_t none;
    none = drive_of(0, 1'b0, ST_OK, ST_OK, ST_OK);
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      decay_q16[i] = decay_entry(i);
    end
    build_plan();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].s, plan[i].known, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      calm = (ph == 1 || ph == 4);
      case (ph)
        0: begin
          write_reg(REG_MAX_POWER, 11'd100);
          write_reg(REG_BED_LIMIT, 11'd880);
          write_reg(REG_SURFACE_LIMIT, 11'd720);
          write_reg(REG_LIQUID_LIMIT, 11'd640);
        end
        1: begin
          write_reg(REG_MAX_POWER, 11'd127);
          write_reg(REG_BED_LIMIT, 11'd1280);
          write_reg(REG_SURFACE_LIMIT, 11'd1280);
          write_reg(REG_LIQUID_LIMIT, 11'd1280);
        end
        2: begin
          write_reg(REG_MAX_POWER, 11'd1);
          write_reg(REG_BED_LIMIT, 11'd2047);
          write_reg(REG_SURFACE_LIMIT, 11'd2047);
          write_reg(REG_LIQUID_LIMIT, 11'd2047);
        end
        default: begin
          write_reg(REG_MAX_POWER, 11'($urandom_range(127, 0)));
          write_reg(REG_BED_LIMIT, random_limit());
          write_reg(REG_SURFACE_LIMIT, random_limit());
          write_reg(REG_LIQUID_LIMIT, random_limit());
        end
      endcase
      repeat (PHASE_ITEMS) send_sample(make_sample(), 1'b0, none);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("[heater_power_safety_controller_top] OK");
    end else begin
      $display("[heater_power_safety_controller_top] ERROR");
    end
    $finish;
  end

endmodule
